FILE: src/scale_note_quantizer_defines.svh
// Assertion helpers for the scale note quantizer checker.
`ifndef SCALE_NOTE_QUANTIZER_DEFINES_SVH
`define SCALE_NOTE_QUANTIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SNQ_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SNQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/snq_pkg.sv
`default_nettype none

package snq_pkg;

  localparam int unsigned TableEntriesDef = 62;
  localparam int unsigned QueueDepthDef   = 2;
  localparam int unsigned NotesPerOctave  = 12;
  localparam int unsigned OctaveBase      = 3;

  localparam int unsigned SampleW  = 12;
  localparam int unsigned CodeW    = 12;
  localparam int unsigned MaskW    = 12;
  localparam int unsigned SensW    = 4;
  localparam int unsigned OctW     = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned GainW    = 5;
  localparam int unsigned ScaledW  = 17;

  // scaled sample is 20x the gained voltage; thresholds compared at 80x
  localparam logic [ScaledW-1:0] ScaledMax = 17'd81900;
  localparam logic [ScaledW-1:0] HystLimit = 17'd200;
  localparam int unsigned ThrStep   = 1360;  // 80 * 17 per semitone
  localparam int unsigned ThrOffset = 640;   // 80 * 8
  localparam int unsigned NoteMul   = 273;
  localparam logic [CodeW-1:0] CodeMax = 12'd4095;

  localparam logic [MaskW-1:0] MaskRst = 12'hFFF;
  localparam logic [SensW-1:0] SensRst = 4'd4;
  localparam logic [OctW-1:0]  OctRst  = 3'd3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SCALE_MASK   = 2'd0,
    REG_SENSITIVITY  = 2'd1,
    REG_OCTAVE_SHIFT = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_PICK,
    ST_CODE,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    logic [ScaledW-1:0] scaled;
    logic               search;
  } snq_item_t;

  typedef struct packed {
    logic [MaskW-1:0] scale_mask;
    logic [SensW-1:0] sensitivity;
    logic [OctW-1:0]  octave_shift;
  } snq_cfg_t;

endpackage

`default_nettype wire

FILE: src/snq_queue.sv
`default_nettype none

module snq_queue import snq_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  snq_item_t push_item_i,
  output logic      full_o,
  input  logic      pop_i,
  output snq_item_t pop_item_o,
  output logic      valid_o
);

  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  snq_item_t       mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  assign full_o     = (cnt_q == CNTW'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ptr_inc(wr_q) : wr_q;
    rd_d  = pop_i ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/snq_front.sv
`default_nettype none

module snq_front import snq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [SampleW-1:0] sample_i,
  input  logic [SampleW-1:0] previous_sample_i,
  input  logic [SensW-1:0]   sensitivity_i,
  output logic               push_o,
  output snq_item_t          push_item_o,
  input  logic               full_i
);

  // stage 1: captured word
  logic               s1_vld_q;
  logic [SampleW-1:0] smp_q, prev_q;
  // stage 2: gained sample
  logic               s2_vld_q;
  logic [ScaledW-1:0] prod_q;
  logic [SampleW-1:0] prev2_q;

  logic               s2_free, s1_free, accept;
  logic [GainW-1:0]   gain;
  logic [ScaledW-1:0] scaled, prev20, diff;

  assign push_o     = s2_vld_q && !full_i;
  assign s2_free    = !s2_vld_q || push_o;
  assign s1_free    = !s1_vld_q || s2_free;
  assign in_stall_o = !s1_free;
  assign accept     = in_valid_i && s1_free;

  assign gain = {1'b1, sensitivity_i};  // 16 + sensitivity

  always_comb begin
    scaled = (prod_q > ScaledMax) ? ScaledMax : prod_q;
    prev20 = ScaledW'({prev2_q, 4'b0}) + ScaledW'({prev2_q, 2'b0});
    diff   = (prev20 >= scaled) ? (prev20 - scaled) : (scaled - prev20);
    push_item_o.scaled = scaled;
    push_item_o.search = (diff > HystLimit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_vld_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q  <= sample_i;
      prev_q <= previous_sample_i;
    end
    if (s2_free && s1_vld_q) begin
      prod_q  <= ScaledW'(smp_q) * ScaledW'(gain);
      prev2_q <= prev_q;
    end
  end

endmodule

`default_nettype wire

FILE: src/snq_back.sv
`default_nettype none

module snq_back import snq_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  snq_cfg_t         cfg_i,
  input  logic             q_valid_i,
  input  snq_item_t        q_item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CodeW-1:0] cv_value_o,
  output logic             updated_o
);

  localparam int unsigned JW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned TW  = $clog2(ThrStep * (TABLE_ENTRIES - 1) + 1);
  localparam int unsigned CW  = (TW > ScaledW) ? TW : ScaledW;
  localparam int unsigned NW  = JW + 3;
  localparam int unsigned VW  = NW + 9;
  localparam int unsigned QW  = VW - 2;

  // a bracket spans at most one octave, so distances stay below 2^14;
  // floor(x / 20) = floor(floor(x / 4) / 5), the divide by 5 by reciprocal
  localparam int unsigned DqW    = 12;
  localparam int unsigned PrW    = 2 * DqW;
  localparam int unsigned Div5Sh = 14;
  localparam logic [DqW-1:0] Div5Mul = 12'd3277;  // ceil(2^14 / 5), exact below 2^14

  back_state_e state_q, state_d;

  logic [JW-1:0]   j_q, jlo_q, sel_j;
  logic [3:0]      m_q;
  logic [CW-1:0]   thr_q, thr_lo_q, sp_q, dist_lo, dist_hi;
  logic            have_lo_q;
  logic [NW-1:0]   n_q, n_d;
  logic [CodeW-1:0] held_q, code;
  logic            upd_q;
  logic            out_vld_q, out_upd_q;
  logic [CodeW-1:0] out_cv_q;

  logic [DqW-1:0]          dq_lo_q, dq_hi_q;
  logic [PrW-1:0]          ql_prod, qh_prod;
  logic [PrW-Div5Sh-1:0]   d_lo, d_hi;

  logic [6:0]            oct12;
  logic signed [VW-1:0]  n_ext, v;
  logic [QW-1:0]         vq;

  logic en, above, last, out_free;
  logic adv, load_lo, emit;

  assign en       = cfg_i.scale_mask[m_q];
  assign above    = (sp_q < thr_q);
  assign last     = (j_q == JW'(TABLE_ENTRIES - 1));
  assign out_free = !out_vld_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = q_item_i.search ? ST_WALK : ST_EMIT;
        end
      end
      ST_WALK: begin
        if (en && above) begin
          state_d = have_lo_q ? ST_PICK : ST_EMIT;
        end else if (last) begin
          state_d = ST_EMIT;
        end
      end
      ST_PICK: state_d = ST_CODE;
      ST_CODE: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o   = 1'b0;
    adv     = 1'b0;
    load_lo = 1'b0;
    emit    = 1'b0;
    unique case (state_q)
      ST_IDLE: pop_o = q_valid_i;
      ST_WALK: begin
        adv     = !(en && above) && !last;
        load_lo = en && !above;
      end
      ST_EMIT: emit = out_free;
      default: ;
    endcase
  end

  // nearer note by whole 20ths of distance; upper wins when they tie
  always_comb begin
    dist_lo = sp_q - thr_lo_q;
    dist_hi = thr_q - sp_q;
    ql_prod = PrW'(dq_lo_q) * PrW'(Div5Mul);
    qh_prod = PrW'(dq_hi_q) * PrW'(Div5Mul);
    d_lo    = ql_prod[PrW-1:Div5Sh];
    d_hi    = qh_prod[PrW-1:Div5Sh];
    sel_j   = (d_lo >= d_hi) ? j_q : jlo_q;
    oct12   = 7'({cfg_i.octave_shift, 3'b0}) + 7'({cfg_i.octave_shift, 2'b0});
    n_d     = NW'(sel_j) + NW'(oct12) - NW'(OctaveBase * NotesPerOctave);
  end

  always_comb begin
    n_ext = {{(VW - NW){n_q[NW-1]}}, n_q};
    v     = n_ext * $signed(VW'(NoteMul));
    vq    = v[VW-1:2];
    if (v[VW-1]) begin
      code = '0;
    end else if (vq > QW'(CodeMax)) begin
      code = CodeMax;
    end else begin
      code = vq[CodeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      held_q    <= '0;
      out_vld_q <= 1'b0;
      have_lo_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        have_lo_q <= 1'b0;
      end else if (load_lo) begin
        have_lo_q <= 1'b1;
      end
      if (state_q == ST_CODE) begin
        held_q <= code;
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sp_q  <= CW'(q_item_i.scaled) + CW'(ThrOffset);
      j_q   <= '0;
      m_q   <= '0;
      thr_q <= '0;
      upd_q <= 1'b0;
    end else if (adv) begin
      j_q   <= j_q + JW'(1);
      m_q   <= (m_q == 4'(NotesPerOctave - 1)) ? 4'd0 : m_q + 4'd1;
      thr_q <= thr_q + CW'(ThrStep);
    end
    if (load_lo) begin
      jlo_q    <= j_q;
      thr_lo_q <= thr_q;
    end
    // quarter distances; the last walk cycle holds the bracketing pair
    if (state_q == ST_WALK) begin
      dq_lo_q <= dist_lo[DqW+1:2];
      dq_hi_q <= dist_hi[DqW+1:2];
    end
    if (state_q == ST_PICK) begin
      n_q <= n_d;
    end
    if (state_q == ST_CODE) begin
      upd_q <= 1'b1;
    end
    if (emit) begin
      out_cv_q  <= held_q;
      out_upd_q <= upd_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign cv_value_o  = out_cv_q;
  assign updated_o   = out_upd_q;

endmodule

`default_nettype wire

FILE: src/scale_note_quantizer.sv
//  channel  | dir | handshake                | payload
//  ---------+-----+--------------------------+-------------------------------
//  in       | in  | in_valid_i / in_stall_o  | sample_i, previous_sample_i
//  out      | out | out_valid_o / out_stall_i| cv_value_o, updated_o
//  cfg      | in  | cfg_we_i (no wait)       | cfg_idx_i, cfg_wdata_i
//
//  A word passes the front's capture and gain stages before it is queued.
//  In the back a hold word goes from idle straight to emit; a search word
//  walks one semitone index per cycle, then reaches emit, via pick and
//  code when a lower note was found. The walk sets the sustained rate.
//  Reset loads scale_mask 0xFFF, sensitivity 4, octave_shift 3 and a held
//  output of 0; the threshold table follows scale_mask, so no clearing pass.
//  in_stall_o rises only when the queue fills; out_stall_i freezes the
//  output register while the front keeps taking words.
`default_nettype none

module scale_note_quantizer import snq_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned QUEUE_DEPTH   = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SampleW-1:0]  sample_i,
  input  logic [SampleW-1:0]  previous_sample_i,
  // config writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CodeW-1:0]    cv_value_o,
  output logic                updated_o
);

  snq_cfg_t  cfg_q;
  logic      push, q_full, pop, q_valid;
  snq_item_t push_item, pop_item;

  // Config registers. The user must write them only while idle, so no
  // shadowing is needed (not enforced here). Unknown index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale_mask   <= MaskRst;
      cfg_q.sensitivity  <= SensRst;
      cfg_q.octave_shift <= OctRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SCALE_MASK:   cfg_q.scale_mask   <= cfg_wdata_i[MaskW-1:0];
        REG_SENSITIVITY:  cfg_q.sensitivity  <= cfg_wdata_i[SensW-1:0];
        REG_OCTAVE_SHIFT: cfg_q.octave_shift <= cfg_wdata_i[OctW-1:0];
        default: ;
      endcase
    end
  end

  // Front: gain the sample, clamp, and sort into hold or search by the
  // change hysteresis against the previous sample.
  snq_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_i          (sample_i),
    .previous_sample_i (previous_sample_i),
    .sensitivity_i     (cfg_q.sensitivity),
    .push_o            (push),
    .push_item_o       (push_item),
    .full_i            (q_full)
  );

  // Short queue decoupling the front from the semitone walk.
  snq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .valid_o     (q_valid)
  );

  // Back: walk enabled semitones for the bracketing pair, pick the nearer
  // note, convert to a DAC code and keep it as the held output.
  snq_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cv_value_o  (cv_value_o),
    .updated_o   (updated_o)
  );

endmodule

`default_nettype wire

FILE: src/snq_checker.sv
`default_nettype none
`include "scale_note_quantizer_defines.svh"

module snq_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [11:0] cv_value_o,
  input wire        updated_o
);

  logic       in_acc, out_acc;
  logic [7:0] pend_q;
  logic [11:0] last_cv_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // words taken but not yet delivered, and the last delivered code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      last_cv_q <= '0;
    end else begin
      if (in_acc && !out_acc) begin
        pend_q <= pend_q + 8'd1;
      end else if (out_acc && !in_acc) begin
        pend_q <= pend_q - 8'd1;
      end
      if (out_acc) begin
        last_cv_q <= cv_value_o;
      end
    end
  end

  `SNQ_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "out valid dropped")
  `SNQ_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(cv_value_o) && $stable(updated_o), "stalled out word changed")
  `SNQ_ASSERT(a_hold_repeat, out_valid_o && !updated_o, cv_value_o == last_cv_q, "held code changed without update")
  `SNQ_ASSERT(a_no_spurious, out_valid_o, pend_q != 8'd0, "result word without input word")

endmodule

bind scale_note_quantizer snq_checker u_snq_checker (.*);

`default_nettype wire
